>>> rtl/core/aacn_pkg.sv
// aacn_pkg: shared types, constants and rate table functions for the config normalizer
// used by aacn_parser and aac_lc_config_normalizer_core; no dependencies
package aacn_pkg;

    localparam int RATE_COUNT = 13;

    localparam logic [4:0]  OBJ_TYPE_LC   = 5'd2;
    localparam logic [3:0]  FREQ_ESCAPE   = 4'd15;
    localparam logic [6:0]  ESC_CH_GA     = 7'h10;
    localparam logic [5:0]  PCE_B2_FIXED  = 6'b000001;
    localparam logic [5:0]  PCE_B3_FIXED  = 6'b000100;
    localparam logic [7:0]  PCE_B6_FIXED  = 8'h20;
    localparam logic [23:0] SYNC_EXT      = 24'h56e500;
    localparam logic [7:0]  SYNC_BYTE0    = 8'h56;
    localparam logic [7:0]  SYNC_BYTE1    = 8'he5;
    localparam logic [7:0]  NORM_OT_BITS  = 8'h10;
    localparam logic [6:0]  NORM_CH_BITS  = 7'h10;
    localparam logic [2:0]  LEN_PLAIN     = 3'd2;
    localparam logic [2:0]  LEN_EXT       = 3'd5;
    localparam logic [2:0]  TAIL_EXT_BYTES = 3'd3;
    localparam logic [2:0]  TAIL_SAT      = 3'd4;

    typedef enum logic [3:0] {
        S_B0,
        S_B1,
        S_ESC2,
        S_ESC3,
        S_ESC4,
        S_PCE2,
        S_PCE3,
        S_PCE4,
        S_PCE5,
        S_PCE6,
        S_CCOUNT,
        S_CSKIP,
        S_TAIL,
        S_FAIL
    } t_state;

    typedef struct packed {
        logic       ok;
        logic       ext;
        logic [3:0] rate_index;
    } t_verdict;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_lookup;

    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

    function automatic t_lookup rate_lookup(input logic [23:0] value);
        t_lookup res;
        res = '0;
        for (int i = 0; i < RATE_COUNT; i++) begin
            if (value == {7'd0, rate_hz(4'(i))}) begin
                res.hit = 1'b1;
                res.idx = 4'(i);
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/aacn_parser.sv
// aacn_parser: byte-wise parse state of one config and the verdict on its last byte
// depends on aacn_pkg
module aacn_parser import aacn_pkg::*; #(
    parameter int MAX_CONFIG_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_verdict   o_verdict
);

    localparam int CNT_W = $clog2(MAX_CONFIG_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONFIG_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);

    t_state             r_state,    n_state;
    logic [2:0]         r_freq_hi,  n_freq_hi;
    logic [3:0]         r_rate,     n_rate;
    logic [22:0]        r_accum,    n_accum;
    logic [7:0]         r_comment,  n_comment;
    logic [2:0]         r_tail_cnt, n_tail_cnt;
    logic [23:0]        r_tail_pat, n_tail_pat;
    logic               r_tail_nz,  n_tail_nz;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;

    logic [3:0]         freq;
    t_lookup            esc_hit;
    logic               ext;

    assign freq    = {r_freq_hi, i_byte[7]};
    assign esc_hit = rate_lookup({r_accum, i_byte[7]});

    always_comb begin
        n_state    = r_state;
        n_freq_hi  = r_freq_hi;
        n_rate     = r_rate;
        n_accum    = r_accum;
        n_comment  = r_comment;
        n_tail_cnt = r_tail_cnt;
        n_tail_pat = r_tail_pat;
        n_tail_nz  = r_tail_nz;
        n_cnt      = (r_cnt <= CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;
        case (r_state)
            S_B0: begin
                n_freq_hi = i_byte[2:0];
                n_state   = (i_byte[7:3] == OBJ_TYPE_LC) ? S_B1 : S_FAIL;
            end
            S_B1: begin
                n_accum = {16'd0, i_byte[6:0]};
                if (freq == FREQ_ESCAPE) begin
                    n_state = S_ESC2;
                end else if (freq >= 4'(RATE_COUNT) || i_byte[6:0] != 7'd0) begin
                    n_state = S_FAIL;
                end else begin
                    n_rate  = freq;
                    n_state = S_PCE2;
                end
            end
            S_ESC2: begin
                n_accum = {r_accum[14:0], i_byte};
                n_state = S_ESC3;
            end
            S_ESC3: begin
                n_accum = {r_accum[14:0], i_byte};
                n_state = S_ESC4;
            end
            S_ESC4: begin
                n_rate  = esc_hit.idx;
                n_state = (esc_hit.hit && i_byte[6:0] == ESC_CH_GA) ? S_TAIL : S_FAIL;
            end
            S_PCE2: begin
                n_state = (i_byte[7:2] == PCE_B2_FIXED && i_byte[1:0] == r_rate[3:2])
                          ? S_PCE3 : S_FAIL;
            end
            S_PCE3: begin
                n_state = (i_byte[7:6] == r_rate[1:0] && i_byte[5:0] == PCE_B3_FIXED)
                          ? S_PCE4 : S_FAIL;
            end
            S_PCE4: begin
                n_state = (i_byte == 8'd0) ? S_PCE5 : S_FAIL;
            end
            S_PCE5: begin
                n_state = (i_byte == 8'd0) ? S_PCE6 : S_FAIL;
            end
            S_PCE6: begin
                n_state = (i_byte == PCE_B6_FIXED) ? S_CCOUNT : S_FAIL;
            end
            S_CCOUNT: begin
                n_comment = i_byte;
                n_state   = (i_byte == 8'd0) ? S_TAIL : S_CSKIP;
            end
            S_CSKIP: begin
                n_comment = r_comment - 8'd1;
                n_state   = (r_comment == 8'd1) ? S_TAIL : S_CSKIP;
            end
            S_TAIL: begin
                n_tail_cnt = (r_tail_cnt < TAIL_SAT) ? r_tail_cnt + 3'd1 : r_tail_cnt;
                n_tail_pat = {r_tail_pat[15:0], i_byte};
                n_tail_nz  = r_tail_nz | (i_byte != 8'd0);
            end
            default: begin
                n_state = S_FAIL;
            end
        endcase
    end

    // verdict includes the current byte
    always_comb begin
        ext = (n_tail_cnt == TAIL_EXT_BYTES) && (n_tail_pat == SYNC_EXT);
        o_verdict.ok = (n_state == S_TAIL) && (n_cnt >= CNT_MIN) && (n_cnt <= CNT_MAX)
                       && (ext || !n_tail_nz);
        o_verdict.ext        = ext;
        o_verdict.rate_index = n_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_state    <= S_B0;
            r_freq_hi  <= '0;
            r_rate     <= '0;
            r_accum    <= '0;
            r_comment  <= '0;
            r_tail_cnt <= '0;
            r_tail_pat <= '0;
            r_tail_nz  <= 1'b0;
            r_cnt      <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_freq_hi  <= n_freq_hi;
            r_rate     <= n_rate;
            r_accum    <= n_accum;
            r_comment  <= n_comment;
            r_tail_cnt <= n_tail_cnt;
            r_tail_pat <= n_tail_pat;
            r_tail_nz  <= n_tail_nz;
            r_cnt      <= n_cnt;
        end
    end

endmodule

>>> rtl/core/aac_lc_config_normalizer_core.sv
// aac_lc_config_normalizer_core: top level, input register, parser and result register
// depends on aacn_pkg and aacn_parser
// path: input register then result register; o_valid is set when the last byte steps
// out of the input register, which waits while the previous result is stalled
// throughput: one byte per cycle; a last byte waits only while the result is stalled
// reset: synchronous active-low, clears parse state and both valid flags
module aac_lc_config_normalizer_core import aacn_pkg::*; #(
    parameter int MAX_CONFIG_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [2:0]  o_out_length,
    output logic [7:0]  o_norm_byte0,
    output logic [7:0]  o_norm_byte1,
    output logic [7:0]  o_norm_byte2,
    output logic [7:0]  o_norm_byte3,
    output logic [7:0]  o_norm_byte4,
    output logic [16:0] o_sample_rate
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_verdict   r_res;
    t_verdict   verdict;
    logic       out_free;
    logic       step;
    logic       in_xfer;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !step;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    aacn_parser #(
        .MAX_CONFIG_BYTES(MAX_CONFIG_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_res <= verdict;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_res.ok;
    assign o_out_length  = !r_res.ok ? 3'd0 : (r_res.ext ? LEN_EXT : LEN_PLAIN);
    assign o_norm_byte0  = r_res.ok ? (NORM_OT_BITS | {5'd0, r_res.rate_index[3:1]}) : 8'd0;
    assign o_norm_byte1  = r_res.ok ? {r_res.rate_index[0], NORM_CH_BITS} : 8'd0;
    assign o_norm_byte2  = (r_res.ok && r_res.ext) ? SYNC_BYTE0 : 8'd0;
    assign o_norm_byte3  = (r_res.ok && r_res.ext) ? SYNC_BYTE1 : 8'd0;
    assign o_norm_byte4  = 8'd0;
    assign o_sample_rate = r_res.ok ? rate_hz(r_res.rate_index) : 17'd0;

endmodule

>>> rtl/core/aacn_checker.sv
// aacn_checker: port-level assertions for aac_lc_config_normalizer_core
// bound to the top level below; no package dependency
module aacn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_ok,
    input logic [2:0]  o_out_length,
    input logic [7:0]  o_norm_byte0,
    input logic [7:0]  o_norm_byte1,
    input logic [7:0]  o_norm_byte2,
    input logic [7:0]  o_norm_byte3,
    input logic [7:0]  o_norm_byte4,
    input logic [16:0] o_sample_rate
);

    // stalled input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte) && $stable(i_last))
        else $error("stalled input changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_out_length)
                               && $stable(o_sample_rate) && $stable(o_norm_byte0))
        else $error("stalled result changed");

    // accepted config has a legal length and a table rate
    a_ok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> (o_out_length == 3'd2 || o_out_length == 3'd5)
                            && o_sample_rate != 17'd0 && o_norm_byte4 == 8'd0)
        else $error("accepted result malformed");

    // rejected config gives all zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_out_length == 3'd0 && o_sample_rate == 17'd0
                             && o_norm_byte0 == 8'd0 && o_norm_byte1 == 8'd0
                             && o_norm_byte2 == 8'd0 && o_norm_byte3 == 8'd0)
        else $error("rejected result not zero");

    // sync extension bytes follow the length
    a_ext_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_length == 3'd5 |-> o_norm_byte2 == 8'h56 && o_norm_byte3 == 8'he5)
        else $error("extension bytes wrong");

endmodule

bind aac_lc_config_normalizer_core aacn_checker u_aacn_checker (.*);

>>> tb/sv/aacn_config_checker.sv
// aacn_config_checker: watches both channels of the config normalizer, predicts each verdict
// from the accepted bytes and compares it field by field; depends on aacn_pkg
`timescale 1ns / 1ps

module aacn_config_checker import aacn_pkg::*; #(
    parameter int MAX_CONFIG_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_ok,
    input  logic [2:0]  i_out_length,
    input  logic [7:0]  i_norm_byte0,
    input  logic [7:0]  i_norm_byte1,
    input  logic [7:0]  i_norm_byte2,
    input  logic [7:0]  i_norm_byte3,
    input  logic [7:0]  i_norm_byte4,
    input  logic [16:0] i_sample_rate,
    output int unsigned o_errors,
    output int unsigned o_pending
);

    localparam int STEP_OT     = 0;
    localparam int STEP_FREQ   = 1;
    localparam int STEP_ESC    = 2;
    localparam int STEP_CH     = 3;
    localparam int STEP_GA     = 4;
    localparam int STEP_PCE    = 5;
    localparam int PCE_COUNT   = 12;
    localparam int STEP_ALIGN  = 17;
    localparam int STEP_CCOUNT = 18;
    localparam int STEP_CSKIP  = 19;
    localparam int STEP_TAIL   = 20;
    localparam int TAIL_SAT_BITS = 25;

    typedef struct packed {
        logic        ok;
        logic [2:0]  length;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [16:0] rate;
    } t_norm_result;

    t_norm_result verdict_q[$];
    int unsigned  err_count = 0;

    int          cfg_bytes;
    int          step;
    int          field_bits;
    logic [23:0] field_val;
    logic [3:0]  rate_idx;
    bit          escaped;
    int          comments_left;
    int          tail_len;
    logic [23:0] tail_shift;
    bit          tail_dirty;
    bit          broken;

    function automatic logic [16:0] rate_of(input int idx);
        case (idx)
            0:       return 17'd96000;
            1:       return 17'd88200;
            2:       return 17'd64000;
            3:       return 17'd48000;
            4:       return 17'd44100;
            5:       return 17'd32000;
            6:       return 17'd24000;
            7:       return 17'd22050;
            8:       return 17'd16000;
            9:       return 17'd12000;
            10:      return 17'd11025;
            11:      return 17'd8000;
            12:      return 17'd7350;
            default: return 17'd0;
        endcase
    endfunction

    function automatic int pce_width(input int k);
        case (k)
            1, 6:    return 2;
            7, 9:    return 3;
            10:      return 1;
            default: return 4;
        endcase
    endfunction

    function automatic int pce_want(input int k);
        case (k)
            1, 3, 10: return 1;
            2:        return int'(rate_idx);
            default:  return 0;
        endcase
    endfunction

    function automatic int field_width(input int s);
        if (s == STEP_OT) return 5;
        if (s == STEP_FREQ || s == STEP_CH) return 4;
        if (s == STEP_ESC) return 24;
        if (s == STEP_GA) return 3;
        if (s >= STEP_PCE && s < STEP_PCE + PCE_COUNT) return pce_width(s - STEP_PCE);
        return 8;
    endfunction

    task automatic clear_parse();
        cfg_bytes     = 0;
        step          = STEP_OT;
        field_bits    = 0;
        field_val     = '0;
        rate_idx      = '0;
        escaped       = 1'b0;
        comments_left = 0;
        tail_len      = 0;
        tail_shift    = '0;
        tail_dirty    = 1'b0;
        broken        = 1'b0;
    endtask

    task automatic close_field(input logic [23:0] v);
        int i;
        int found;
        int k;
        found = RATE_COUNT;
        k = step - STEP_PCE;
        if (step == STEP_OT) begin
            if (v != 24'(OBJ_TYPE_LC)) broken = 1'b1;
            else step = STEP_FREQ;
        end else if (step == STEP_FREQ) begin
            if (v == 24'(FREQ_ESCAPE)) begin
                escaped = 1'b1;
                step = STEP_ESC;
            end else if (v >= 24'(RATE_COUNT)) begin
                broken = 1'b1;
            end else begin
                rate_idx = v[3:0];
                step = STEP_CH;
            end
        end else if (step == STEP_ESC) begin
            for (i = 0; i < RATE_COUNT; i++)
                if (v == {7'd0, rate_of(i)}) found = i;
            if (found >= RATE_COUNT) broken = 1'b1;
            else begin
                rate_idx = 4'(found);
                step = STEP_CH;
            end
        end else if (step == STEP_CH) begin
            if (v != (escaped ? 24'd2 : 24'd0)) broken = 1'b1;
            else step = STEP_GA;
        end else if (step == STEP_GA) begin
            if (v != 24'd0) broken = 1'b1;
            else step = escaped ? STEP_TAIL : STEP_PCE;
        end else if (step >= STEP_PCE && step < STEP_PCE + PCE_COUNT) begin
            if (int'(v) != pce_want(k)) broken = 1'b1;
            else step = (k + 1 == PCE_COUNT) ? STEP_ALIGN : step + 1;
        end else if (step == STEP_CCOUNT) begin
            comments_left = int'(v[7:0]);
            step = (comments_left != 0) ? STEP_CSKIP : STEP_TAIL;
        end else if (step == STEP_CSKIP) begin
            if (comments_left != 0) comments_left--;
            if (comments_left == 0) step = STEP_TAIL;
        end else begin
            broken = 1'b1;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic is_last,
                             output bit has_res, output t_norm_result res);
        int          i;
        logic        bt;
        logic [23:0] v;
        bit          ok;
        bit          ext;
        has_res = 1'b0;
        res = '0;
        ext = 1'b0;
        if (cfg_bytes <= MAX_CONFIG_BYTES) cfg_bytes++;
        for (i = 0; i < 8 && !broken; i++) begin
            bt = b[7 - i];
            if (step == STEP_ALIGN) begin
                if (i == 0) step = STEP_CCOUNT;
                else begin
                    if (bt) broken = 1'b1;
                    continue;
                end
            end
            if (step == STEP_TAIL) begin
                if (tail_len < TAIL_SAT_BITS) tail_len++;
                tail_shift = {tail_shift[22:0], bt};
                if (bt) tail_dirty = 1'b1;
                continue;
            end
            field_val = {field_val[22:0], bt};
            field_bits++;
            if (field_bits >= field_width(step)) begin
                v = field_val;
                field_val = '0;
                field_bits = 0;
                close_field(v);
            end
        end
        if (is_last) begin
            ok = !broken && step == STEP_TAIL && cfg_bytes >= 2 &&
                 cfg_bytes <= MAX_CONFIG_BYTES;
            if (ok) begin
                if (tail_len == 24 && tail_shift == SYNC_EXT) ext = 1'b1;
                else if (tail_dirty) ok = 1'b0;
            end
            has_res = 1'b1;
            if (ok) begin
                res.ok     = 1'b1;
                res.length = ext ? LEN_EXT : LEN_PLAIN;
                res.b0     = NORM_OT_BITS | {5'd0, rate_idx[3:1]};
                res.b1     = {rate_idx[0], NORM_CH_BITS};
                res.b2     = ext ? SYNC_BYTE0 : 8'd0;
                res.b3     = ext ? SYNC_BYTE1 : 8'd0;
                res.b4     = 8'd0;
                res.rate   = rate_of(int'(rate_idx));
            end
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_norm_result want;
        t_norm_result fresh;
        bit           produced;
        if (!i_rst_n) begin
            clear_parse();
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual ok=%0b len=%0d",
                             $time, i_ok, i_out_length);
                    err_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("ok", 32'(want.ok), 32'(i_ok));
                    check_field("out_length", 32'(want.length), 32'(i_out_length));
                    check_field("norm_byte0", 32'(want.b0), 32'(i_norm_byte0));
                    check_field("norm_byte1", 32'(want.b1), 32'(i_norm_byte1));
                    check_field("norm_byte2", 32'(want.b2), 32'(i_norm_byte2));
                    check_field("norm_byte3", 32'(want.b3), 32'(i_norm_byte3));
                    check_field("norm_byte4", 32'(want.b4), 32'(i_norm_byte4));
                    check_field("sample_rate", 32'(want.rate), 32'(i_sample_rate));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_data_byte, i_last, produced, fresh);
                if (produced) verdict_q.push_back(fresh);
            end
        end
        o_errors  <= err_count;
        o_pending <= verdict_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
// testbench: drives config byte streams into aac_lc_config_normalizer_core with random
// idling and stalls; checking is done by aacn_config_checker; depends on aacn_pkg
`timescale 1ns / 1ps

module testbench;
    import aacn_pkg::*;

    localparam int MAX_BYTES   = 256;
    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_FROM  = 900;
    localparam int QUIET_TO    = 1300;
    localparam int SETTLE      = 8;

    localparam int TAIL_NONE     = 0;
    localparam int TAIL_ZERO     = 1;
    localparam int TAIL_SYNC     = 2;
    localparam int TAIL_SYNC_PAD = 3;
    localparam int TAIL_JUNK     = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic        o_ok;
    logic [2:0]  o_out_length;
    logic [7:0]  o_norm_byte0;
    logic [7:0]  o_norm_byte1;
    logic [7:0]  o_norm_byte2;
    logic [7:0]  o_norm_byte3;
    logic [7:0]  o_norm_byte4;
    logic [16:0] o_sample_rate;

    int unsigned errors;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int          bytes_sent  = 0;
    bit          tx_steady   = 1'b0;

    bit         bits_q[$];
    logic [7:0] cfg_q[$];

    aac_lc_config_normalizer_core #(
        .MAX_CONFIG_BYTES(MAX_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ok         (o_ok),
        .o_out_length (o_out_length),
        .o_norm_byte0 (o_norm_byte0),
        .o_norm_byte1 (o_norm_byte1),
        .o_norm_byte2 (o_norm_byte2),
        .o_norm_byte3 (o_norm_byte3),
        .o_norm_byte4 (o_norm_byte4),
        .o_sample_rate(o_sample_rate)
    );

    aacn_config_checker #(
        .MAX_CONFIG_BYTES(MAX_BYTES)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_ok         (o_ok),
        .i_out_length (o_out_length),
        .i_norm_byte0 (o_norm_byte0),
        .i_norm_byte1 (o_norm_byte1),
        .i_norm_byte2 (o_norm_byte2),
        .i_norm_byte3 (o_norm_byte3),
        .i_norm_byte4 (o_norm_byte4),
        .i_sample_rate(o_sample_rate),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one quiet stretch
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_cycle == HOLD_AT) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_cycle += HOLD_CYCLES;
            end else begin
                if (rx_cycle >= QUIET_FROM && rx_cycle < QUIET_TO) i_stall <= 1'b0;
                else i_stall <= ($urandom_range(0, 99) < 24);
                @(posedge i_clk);
                rx_cycle++;
            end
        end
    end

    task automatic put_bits(input int unsigned value, input int width);
        int i;
        for (i = width - 1; i >= 0; i--) bits_q.push_back(bit'(value >> i));
    endtask

    task automatic pack_bits();
        int         i;
        int         j;
        logic [7:0] b;
        while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
        for (i = 0; i < bits_q.size(); i += 8) begin
            for (j = 0; j < 8; j++) b[7 - j] = bits_q[i + j];
            cfg_q.push_back(b);
        end
        bits_q.delete();
    endtask

    task automatic add_tail(input int zeros, input int kind);
        if (kind == TAIL_ZERO || kind == TAIL_SYNC_PAD)
            repeat (zeros) cfg_q.push_back(8'd0);
        if (kind == TAIL_SYNC || kind == TAIL_SYNC_PAD) begin
            cfg_q.push_back(SYNC_BYTE0);
            cfg_q.push_back(SYNC_BYTE1);
            cfg_q.push_back(8'd0);
        end
        if (kind == TAIL_JUNK) cfg_q.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic build_escaped(input logic [23:0] rate_val, input int ch,
                                 input int zeros, input int kind);
        put_bits(32'(OBJ_TYPE_LC), 5);
        put_bits(32'(FREQ_ESCAPE), 4);
        put_bits(32'(rate_val), 24);
        put_bits(ch, 4);
        put_bits(0, 3);
        pack_bits();
        add_tail(zeros, kind);
    endtask

    task automatic build_pce(input int hdr_idx, input int pce_idx, input int comments,
                             input int zeros, input int kind);
        put_bits(32'(OBJ_TYPE_LC), 5);
        put_bits(hdr_idx, 4);
        put_bits(0, 4);
        put_bits(0, 3);
        put_bits(0, 4);
        put_bits(1, 2);
        put_bits(pce_idx, 4);
        put_bits(1, 4);
        put_bits(0, 4);
        put_bits(0, 4);
        put_bits(0, 2);
        put_bits(0, 3);
        put_bits(0, 4);
        put_bits(0, 3);
        put_bits(1, 1);
        put_bits(0, 4);
        pack_bits();
        cfg_q.push_back(8'(comments));
        repeat (comments) cfg_q.push_back(8'($urandom));
        add_tail(zeros, kind);
    endtask

    task automatic mutate();
        int pos;
        pos = $urandom_range(0, cfg_q.size() - 1);
        case ($urandom_range(0, 2))
            0: cfg_q[pos] = cfg_q[pos] ^ (8'd1 << $urandom_range(0, 7));
            1: if (cfg_q.size() > 1) cfg_q = cfg_q[0:$urandom_range(0, cfg_q.size() - 2)];
            default: cfg_q[pos] = cfg_q[pos] | 8'($urandom_range(1, 255));
        endcase
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while (!tx_steady && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        i_last      <= is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_config();
        int i;
        for (i = 0; i < cfg_q.size(); i++) send_byte(cfg_q[i], i == cfg_q.size() - 1);
        cfg_q.delete();
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int cfg_num;
        int r;
        int idx;
        int n;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'd0;
        i_last      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: both shapes at the rate table ends, tails, rejects
        build_escaped(24'(rate_hz(4'd0)), 2, 0, TAIL_NONE);
        send_config();
        build_escaped(24'(rate_hz(4'd12)), 2, 0, TAIL_SYNC);
        send_config();
        build_pce(0, 0, 0, 0, TAIL_NONE);
        send_config();
        build_pce(12, 12, 2, 1, TAIL_SYNC);
        send_config();
        build_pce(13, 13, 0, 0, TAIL_NONE);
        send_config();
        build_escaped(24'hffffff, 2, 0, TAIL_NONE);
        send_config();
        build_escaped(24'(rate_hz(4'd3)), 0, 0, TAIL_NONE);
        send_config();
        build_escaped(24'(rate_hz(4'd4)), 2, 1, TAIL_SYNC_PAD);
        send_config();
        cfg_q.push_back(8'h10);
        send_config();
        cfg_q.push_back(8'hff);
        cfg_q.push_back(8'hff);
        send_config();
        // truncated escaped rate
        build_escaped(24'(rate_hz(4'd5)), 2, 0, TAIL_NONE);
        cfg_q = cfg_q[0:2];
        send_config();
        // nonzero alignment bit
        build_pce(3, 3, 0, 0, TAIL_NONE);
        cfg_q[6] = cfg_q[6] | 8'h01;
        send_config();
        // comment count at its top, stream ends inside the comments
        build_pce(7, 7, 0, 0, TAIL_NONE);
        cfg_q[7] = 8'hff;
        repeat (3) cfg_q.push_back(8'($urandom));
        send_config();

        i_valid <= 1'b0;
        drain_results();

        cfg_num = 0;
        while (bytes_sent < ITEM_TARGET) begin
            tx_steady = (cfg_num >= 30 && cfg_num < 50);
            idx = $urandom_range(0, 12);
            r = $urandom_range(0, 99);
            if (cfg_num == 40) begin
                build_pce(idx, idx, MAX_BYTES - 8, 0, TAIL_NONE);
            end else if (cfg_num == 41) begin
                build_escaped(24'(rate_hz(4'(idx))), 2, MAX_BYTES - 4, TAIL_ZERO);
            end else if (r < 35) begin
                build_escaped(24'(rate_hz(4'(idx))), 2, $urandom_range(1, 3),
                              $urandom_range(0, 3));
            end else if (r < 70) begin
                build_pce(idx, idx, $urandom_range(0, 6), $urandom_range(1, 3),
                          $urandom_range(0, 3));
            end else if (r < 85) begin
                if (r[0]) build_escaped(24'(rate_hz(4'(idx))), 2, $urandom_range(0, 2),
                                        $urandom_range(0, 4));
                else build_pce(idx, idx, $urandom_range(0, 4), $urandom_range(0, 2),
                               $urandom_range(0, 4));
                mutate();
            end else if (r < 95) begin
                n = $urandom_range(1, 10);
                repeat (n) cfg_q.push_back(8'($urandom));
            end else if (r < 97) begin
                build_escaped(r[0] ? 24'($urandom) : 24'(rate_hz(4'(idx))) + 24'd1, 2, 0,
                              TAIL_NONE);
            end else begin
                build_pce($urandom_range(13, 15), idx, 0, 0, TAIL_NONE);
            end
            send_config();
            cfg_num++;
        end

        tx_steady = 1'b0;
        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
